/* rtl/core/sht_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sht_pkg: shared types and constants for the scheduled thermostat
// Request/response payload structs, register indexes and clock limits.
// ----------------------------------------------------------------------------
package sht_pkg;

   // Prescale: a second passes when the tick counter exceeds this value.
   localparam logic [1:0] PRESCALE_LIMIT = 2'd2;

   localparam logic [5:0] SEC_PER_MIN  = 6'd60;
   localparam logic [5:0] MIN_PER_HOUR = 6'd60;
   localparam logic [4:0] HOUR_PER_DAY = 5'd24;
   localparam logic [6:0] TEMP_SCALE   = 7'd125;   // degrees = sample*125/256
   localparam logic [6:0] HYST_BAND    = 7'd5;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 7;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SETPOINT     = 3'd0,
      CSR_START_HOUR   = 3'd1,
      CSR_START_MINUTE = 3'd2,
      CSR_STOP_HOUR    = 3'd3,
      CSR_STOP_MINUTE  = 3'd4
   } csr_index_type;

   localparam logic [6:0] SETPOINT_RST     = 7'd40;
   localparam logic [4:0] START_HOUR_RST   = 5'd12;
   localparam logic [5:0] START_MINUTE_RST = 6'd0;
   localparam logic [4:0] STOP_HOUR_RST    = 5'd20;
   localparam logic [5:0] STOP_MINUTE_RST  = 6'd0;
   localparam logic [4:0] HOURS_RST        = 5'd12;

   typedef enum logic {
      ACT_TICK     = 1'b0,
      ACT_SET_TIME = 1'b1
   } action_type;

   typedef struct packed {
      logic       action;
      logic [9:0] sample;
      logic       level_ok;
      logic [4:0] set_hour;
      logic [5:0] set_minute;
   } req_type;

   typedef struct packed {
      logic       heater_on;
      logic       schedule_active;
      logic [8:0] temperature;
      logic [4:0] clock_hour;
      logic [5:0] clock_minute;
      logic [5:0] clock_second;
      logic       level_high;
   } rsp_type;

endpackage

/* rtl/core/scheduled_hysteresis_thermostat_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scheduled_hysteresis_thermostat_unit: tick-driven heater controller
//
// Channels: req_* carries one request (timer tick or set-time action),
// rsp_* returns one response per request with the heater, window and
// clock state after that request. Both use valid/stall; an item moves on
// a rising edge with valid high and stall low. csr_* writes the setpoint
// and schedule start/stop times by index; write only while idle (unguarded).
//
// Latency: the response is valid the cycle after the request is taken.
// Throughput: one request per cycle while req_stall is low; clock rollover,
// temperature scaling and the hysteresis decision are a single combinational
// pass ahead of the state and response registers.
// Stall: a held response keeps rsp_data steady; req_stall rises only
// while a response is held and rsp_stall is high.
// Reset: clock at 12:00:00, window and heater off, registers at defaults,
// no response pending.
// ----------------------------------------------------------------------------
module scheduled_hysteresis_thermostat_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  sht_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output sht_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [sht_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sht_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sht_pkg::*;

   // configuration
   logic [6:0] setpoint_ff;
   logic [4:0] start_hour_ff;
   logic [5:0] start_minute_ff;
   logic [4:0] stop_hour_ff;
   logic [5:0] stop_minute_ff;

   // controller state
   logic [1:0] tick_count_ff, tick_count_in;
   logic [5:0] seconds_ff, seconds_in;
   logic [5:0] minutes_ff, minutes_in;
   logic [4:0] hours_ff, hours_in;
   logic       window_ff, window_in;
   logic       heating_ff, heating_in;
   logic [8:0] temp_ff, temp_in;
   logic       level_ff, level_in;

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic       req_take;

   // tick datapath temporaries
   logic        adv_sec;
   logic [1:0]  tick_base;
   logic [5:0]  sec_inc, min_step, min_roll;
   logic [4:0]  hour_step, hour_roll;
   logic        sec_wrap, min_wrap;
   logic [16:0] product;
   logic [8:0]  temp_new;
   logic        win_mid, heat_mid;
   logic [7:0]  upper_limit;
   logic [9:0]  temp_plus;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff     <= SETPOINT_RST;
         start_hour_ff   <= START_HOUR_RST;
         start_minute_ff <= START_MINUTE_RST;
         stop_hour_ff    <= STOP_HOUR_RST;
         stop_minute_ff  <= STOP_MINUTE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SETPOINT:     setpoint_ff     <= csr_wdata[6:0];
            CSR_START_HOUR:   start_hour_ff   <= csr_wdata[4:0];
            CSR_START_MINUTE: start_minute_ff <= csr_wdata[5:0];
            CSR_STOP_HOUR:    stop_hour_ff    <= csr_wdata[4:0];
            CSR_STOP_MINUTE:  stop_minute_ff  <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // prescale and second advance
      adv_sec   = (tick_count_ff > PRESCALE_LIMIT);
      tick_base = adv_sec ? 2'd0 : tick_count_ff;

      sec_inc  = seconds_ff + 6'd1;
      sec_wrap = (sec_inc >= SEC_PER_MIN);
      min_step = sec_wrap ? (minutes_ff + 6'd1) : minutes_ff;
      // out-of-range loaded values also roll at a second advance
      min_wrap  = (min_step >= MIN_PER_HOUR);
      min_roll  = min_wrap ? 6'd0 : min_step;
      hour_step = min_wrap ? (hours_ff + 5'd1) : hours_ff;
      hour_roll = (hour_step >= HOUR_PER_DAY) ? 5'd0 : hour_step;

      product  = {7'd0, req_data.sample} * {10'd0, TEMP_SCALE};
      temp_new = product[16:8];

      tick_count_in = tick_count_ff;
      seconds_in    = seconds_ff;
      minutes_in    = minutes_ff;
      hours_in      = hours_ff;
      window_in     = window_ff;
      heating_in    = heating_ff;
      temp_in       = temp_ff;
      level_in      = level_ff;
      win_mid       = window_ff;
      heat_mid      = heating_ff;
      upper_limit   = {1'b0, setpoint_ff} + {1'b0, HYST_BAND};
      temp_plus     = {1'b0, temp_new} + {3'd0, HYST_BAND};

      if (req_data.action == ACT_SET_TIME) begin
         hours_in   = req_data.set_hour;
         minutes_in = req_data.set_minute;
      end else begin
         tick_count_in = tick_base + 2'd1;
         if (adv_sec) begin
            seconds_in = sec_wrap ? 6'd0 : sec_inc;
            minutes_in = min_roll;
            hours_in   = hour_roll;
         end
         temp_in = temp_new;

         // start match wins over stop match
         if (minutes_in == start_minute_ff && hours_in == start_hour_ff) begin
            win_mid = 1'b1;
         end else if (minutes_in == stop_minute_ff && hours_in == stop_hour_ff) begin
            win_mid = 1'b0;
         end

         if (win_mid) begin
            if ({1'b0, temp_new} >= {2'b0, upper_limit}) begin
               heat_mid = 1'b0;
            end else if (temp_plus <= {3'd0, setpoint_ff}) begin
               heat_mid = 1'b1;
            end
         end else begin
            heat_mid = 1'b0;
         end

         level_in   = req_data.level_ok;
         window_in  = win_mid & req_data.level_ok;
         heating_in = heat_mid & req_data.level_ok;
      end

      rsp_data_in.heater_on       = heating_in;
      rsp_data_in.schedule_active = window_in;
      rsp_data_in.temperature     = temp_in;
      rsp_data_in.clock_hour      = hours_in;
      rsp_data_in.clock_minute    = minutes_in;
      rsp_data_in.clock_second    = seconds_in;
      rsp_data_in.level_high      = level_in;

      rsp_valid_in = req_take | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= 2'd0;
         seconds_ff    <= 6'd0;
         minutes_ff    <= 6'd0;
         hours_ff      <= HOURS_RST;
         window_ff     <= 1'b0;
         heating_ff    <= 1'b0;
         temp_ff       <= 9'd0;
         level_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            tick_count_ff <= tick_count_in;
            seconds_ff    <= seconds_in;
            minutes_ff    <= minutes_in;
            hours_ff      <= hours_in;
            window_ff     <= window_in;
            heating_ff    <= heating_in;
            temp_ff       <= temp_in;
            level_ff      <= level_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
